>>> rtl/i2cme_pkg.sv
package i2cme_pkg;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_ACK   = 3'd5;
    localparam logic [2:0] CMD_NACK  = 3'd6;

    localparam logic [7:0] PHASE_TICKS_RESET = 8'd4;
    localparam logic [7:0] MSB_MASK          = 8'h80;
    localparam logic [3:0] ACK_BIT           = 4'd8;
    localparam logic [3:0] LAST_WRITE_BIT    = 4'd9;
    localparam logic [2:0] LAST_STEP         = 3'd2;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] phase;
        logic [3:0] bit_idx;
        logic [7:0] ticks;
        logic [7:0] shift;
        logic [7:0] rx;
        logic       nack;
        logic [1:0] lines;   // [1] SCL, [0] SDA
    } t_state;

    localparam t_state STATE_RESET = '{
        cmd:     CMD_NONE,
        phase:   3'd0,
        bit_idx: 4'd0,
        ticks:   8'd0,
        shift:   8'd0,
        rx:      8'd0,
        nack:    1'b0,
        lines:   2'b11
    };

    typedef struct packed {
        logic done;
        logic rejected;
    } t_flags;

endpackage

>>> rtl/i2c_master_byte_engine_unit.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_ready   | i_func, i_tx_byte, i_sda_in
// out     | output    | o_out_valid / i_out_ready | o_scl_out .. o_cmd_rejected
// cfg     | input     | i_cfg_wr_en (no wait)     | i_cfg_wr_data (phase_ticks)
//
// One tick word in, one result word out; one word per cycle unless the output stalls.
// The state update and the result register share the accept edge.
// The single output register sets the rate: a new word enters whenever that
// register is empty or being drained in the same cycle.
// Synchronous active-low reset clears the line state (both lines high) and
// sets phase_ticks to 4; output stalls hold the result and back-pressure input.
module i2c_master_byte_engine_unit import i2cme_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_func,
    input  logic [7:0] i_tx_byte,
    input  logic       i_sda_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_scl_out,
    output logic       o_sda_out,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic [7:0] o_rx_byte,
    output logic       o_ack_error,
    output logic       o_cmd_rejected
);

    t_state     r_state;
    t_state     n_state;
    t_flags     step_flags;
    logic [7:0] r_phase_ticks;
    logic       r_out_valid;
    logic       accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    i2cme_step u_step (
        .i_cur         (r_state),
        .i_phase_ticks (r_phase_ticks),
        .i_func        (i_func),
        .i_tx_byte     (i_tx_byte),
        .i_sda_in      (i_sda_in),
        .o_nxt         (n_state),
        .o_flags       (step_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= STATE_RESET;
            r_phase_ticks <= PHASE_TICKS_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_phase_ticks <= i_cfg_wr_data;
            end
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word: load on accept, hold while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            o_scl_out      <= n_state.lines[1];
            o_sda_out      <= n_state.lines[0];
            o_busy_res     <= (n_state.cmd != CMD_NONE);
            o_done_res     <= step_flags.done;
            o_rx_byte      <= n_state.rx;
            o_ack_error    <= n_state.nack;
            o_cmd_rejected <= step_flags.rejected;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/i2cme_step.sv
module i2cme_step import i2cme_pkg::*; (
    input  t_state     i_cur,
    input  logic [7:0] i_phase_ticks,
    input  logic [2:0] i_func,
    input  logic [7:0] i_tx_byte,
    input  logic       i_sda_in,
    output t_state     o_nxt,
    output t_flags     o_flags
);

    logic [7:0] limit;
    logic [7:0] ticks_inc;
    logic       msb;

    always_comb begin
        o_nxt = i_cur;
        o_flags = '0;
        limit = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;
        ticks_inc = 8'd0;
        msb = 1'b0;

        // start a command, or flag one given while busy
        if (i_cur.cmd != CMD_NONE) begin
            o_flags.rejected = (i_func != CMD_NONE);
        end else if (i_func >= CMD_START && i_func <= CMD_NACK) begin
            o_nxt.cmd = i_func;
            o_nxt.phase = 3'd0;
            o_nxt.bit_idx = 4'd0;
            o_nxt.ticks = 8'd0;
            if (i_func == CMD_WRITE) begin
                o_nxt.shift = i_tx_byte;
                o_nxt.nack = 1'b0;
            end else if (i_func == CMD_READ) begin
                o_nxt.shift = 8'd0;
            end
        end

        if (o_nxt.cmd != CMD_NONE) begin
            msb = ((o_nxt.shift & MSB_MASK) != 8'd0);
            unique case (o_nxt.cmd)
                CMD_START: begin
                    o_nxt.lines = (o_nxt.phase == 3'd0) ? 2'b11 :
                                  (o_nxt.phase == 3'd1) ? 2'b10 : 2'b00;
                end
                CMD_STOP: begin
                    o_nxt.lines = (o_nxt.phase == 3'd0) ? 2'b00 :
                                  (o_nxt.phase == 3'd1) ? 2'b10 : 2'b11;
                end
                CMD_ACK:  o_nxt.lines = (o_nxt.phase == 3'd1) ? 2'b10 : 2'b00;
                CMD_NACK: o_nxt.lines = (o_nxt.phase == 3'd1) ? 2'b11 : 2'b01;
                CMD_WRITE: begin
                    if (o_nxt.bit_idx < ACK_BIT) begin
                        o_nxt.lines = {o_nxt.phase[0], msb};
                    end else if (o_nxt.bit_idx == ACK_BIT) begin
                        o_nxt.lines = {o_nxt.phase[0], 1'b1};
                    end else begin
                        o_nxt.lines = 2'b01;
                    end
                end
                CMD_READ: begin
                    o_nxt.lines = (o_nxt.bit_idx < ACK_BIT) ? {o_nxt.phase[0], 1'b1} : 2'b01;
                end
                default: o_nxt.lines = i_cur.lines;
            endcase

            ticks_inc = o_nxt.ticks + 8'd1;
            o_nxt.ticks = ticks_inc;
            if (ticks_inc >= limit) begin
                o_nxt.ticks = 8'd0;
                // end of phase: advance step, shift, sample
                unique case (o_nxt.cmd)
                    CMD_WRITE: begin
                        if (o_nxt.bit_idx >= LAST_WRITE_BIT) begin
                            o_flags.done = 1'b1;
                        end else if (o_nxt.phase == 3'd0) begin
                            o_nxt.phase = 3'd1;
                        end else begin
                            if (o_nxt.bit_idx == ACK_BIT) begin
                                o_nxt.nack = i_sda_in;
                            end else begin
                                o_nxt.shift = {o_nxt.shift[6:0], 1'b0};
                            end
                            o_nxt.bit_idx = o_nxt.bit_idx + 4'd1;
                            o_nxt.phase = 3'd0;
                        end
                    end
                    CMD_READ: begin
                        if (o_nxt.bit_idx >= ACK_BIT) begin
                            o_nxt.rx = o_nxt.shift;
                            o_flags.done = 1'b1;
                        end else if (o_nxt.phase == 3'd0) begin
                            o_nxt.phase = 3'd1;
                        end else begin
                            o_nxt.shift = {o_nxt.shift[6:0], i_sda_in};
                            o_nxt.bit_idx = o_nxt.bit_idx + 4'd1;
                            o_nxt.phase = 3'd0;
                        end
                    end
                    default: begin
                        if (o_nxt.phase >= LAST_STEP) begin
                            o_flags.done = 1'b1;
                        end else begin
                            o_nxt.phase = o_nxt.phase + 3'd1;
                        end
                    end
                endcase
                if (o_flags.done) begin
                    o_nxt.cmd = CMD_NONE;
                    o_nxt.phase = 3'd0;
                    o_nxt.bit_idx = 4'd0;
                end
            end
        end
    end

endmodule

>>> rtl/i2cme_checker.sv
module i2cme_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_scl_out,
    input logic       o_sda_out,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_rx_byte,
    input logic       o_cmd_rejected
);

    // a finished command is never reported busy in the same word
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_done_res && o_busy_res))
        else $error("done and busy in one word");

    // a rejected command implies one was running
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cmd_rejected) |-> (o_busy_res || o_done_res))
        else $error("reject without active command");

    // input stalls only because a result word is waiting
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output stall");

    // held result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_scl_out) && $stable(o_sda_out) &&
             $stable(o_rx_byte) && $stable(o_done_res)))
        else $error("result word changed while stalled");

endmodule

bind i2c_master_byte_engine_unit i2cme_checker u_i2cme_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_scl_out      (o_scl_out),
    .o_sda_out      (o_sda_out),
    .o_busy_res     (o_busy_res),
    .o_done_res     (o_done_res),
    .o_rx_byte      (o_rx_byte),
    .o_cmd_rejected (o_cmd_rejected)
);
